### design/boxq_pkg.sv
// Shared types and constants for the box distance and overlap query block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package boxq_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned HALF_W     = 31;
  localparam int unsigned DIST_W     = 33;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned ROOT_STEPS = 32;
  // Two lane stages, one merge stage, the root steps and the output register.
  localparam int unsigned NUM_STAGES = ROOT_STEPS + 4;
  localparam int unsigned IN_DATA_W  = 2 * NUM_AXES * COORD_W;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic [COORD_W-1:0] SIZE_RESET = 32'h0001_0000;

  typedef enum logic [1:0] {
    REL_OUTSIDE = 2'd0,
    REL_INSIDE  = 2'd1,
    REL_CROSS   = 2'd2
  } relation_e;

  typedef struct packed {
    logic [SQ_W-1:0]          sq;
    logic signed [DIST_W-1:0] delta;
    logic                     pt_in;
    logic                     bx_out;
    logic                     bx_in;
  } lane_t;

  typedef struct packed {
    logic [SQ_W-1:0]          rem;
    logic [SQ_W-1:0]          root;
    logic signed [DIST_W-1:0] dmax;
    logic                     pt_in;
    relation_e                rel;
    logic                     kind;
  } root_t;

endpackage

### design/boxq_lane.sv
// One axis lane: excess over the half extent, its square and the bound compares.
// Two register stages. Depends on boxq_pkg.
`timescale 1ns / 1ps

module boxq_lane (
  input  logic                                 clk_i,
  input  logic [1:0]                           en_i,
  input  logic signed [boxq_pkg::COORD_W-1:0]  pos_i,
  input  logic signed [boxq_pkg::COORD_W-1:0]  top_i,
  input  logic [boxq_pkg::HALF_W-1:0]          half_i,
  output boxq_pkg::lane_t                      lane_o
);

  logic signed [boxq_pkg::DIST_W-1:0]  pos_ext;
  logic signed [boxq_pkg::DIST_W-1:0]  top_ext;
  logic signed [boxq_pkg::DIST_W-1:0]  half_pos;
  logic signed [boxq_pkg::DIST_W-1:0]  half_neg;
  logic [boxq_pkg::COORD_W-1:0]        mag;
  logic signed [boxq_pkg::DIST_W-1:0]  delta_d;
  logic signed [boxq_pkg::DIST_W-1:0]  delta_q;
  logic [boxq_pkg::COORD_W-1:0]        exc_d;
  logic [boxq_pkg::COORD_W-1:0]        exc_q;
  logic                                pt_in_q;
  logic                                bx_out_q;
  logic                                bx_in_q;
  boxq_pkg::lane_t                     lane_q;

  always_comb begin
    pos_ext  = {pos_i[boxq_pkg::COORD_W-1], pos_i};
    top_ext  = {top_i[boxq_pkg::COORD_W-1], top_i};
    half_pos = $signed({2'b00, half_i});
    half_neg = -half_pos;
    mag      = pos_i[boxq_pkg::COORD_W-1] ? (~pos_i + 1'b1) : pos_i;
    delta_d  = $signed({1'b0, mag}) - half_pos;
    if (!delta_d[boxq_pkg::DIST_W-1] && (delta_d != '0)) begin
      exc_d = delta_d[boxq_pkg::COORD_W-1:0];
    end else begin
      exc_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      delta_q  <= delta_d;
      exc_q    <= exc_d;
      pt_in_q  <= (pos_ext >= half_neg) && (pos_ext <= half_pos);
      bx_out_q <= (top_ext < half_neg) || (pos_ext > half_pos);
      bx_in_q  <= (pos_ext >= half_neg) && (top_ext <= half_pos);
    end
    if (en_i[1]) begin
      lane_q.sq     <= exc_q * exc_q;
      lane_q.delta  <= delta_q;
      lane_q.pt_in  <= pt_in_q;
      lane_q.bx_out <= bx_out_q;
      lane_q.bx_in  <= bx_in_q;
    end
  end

  assign lane_o = lane_q;

endmodule

### design/boxq_merge.sv
// Merge stage: sums the lane squares, picks the largest axis delta capped at zero and
// classifies bounds. One register stage. Depends on boxq_pkg.
`timescale 1ns / 1ps

module boxq_merge (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  boxq_pkg::lane_t [boxq_pkg::NUM_AXES-1:0] lane_i,
  input  logic                                   kind_i,
  output boxq_pkg::root_t                        merge_o
);

  logic [boxq_pkg::SQ_W-1:0]           sum;
  logic signed [boxq_pkg::DIST_W-1:0]  dmax;
  logic                                any_out;
  logic                                all_in;
  boxq_pkg::relation_e                 rel;
  boxq_pkg::root_t                     merge_q;

  always_comb begin
    sum  = lane_i[0].sq + lane_i[1].sq + lane_i[2].sq;
    dmax = lane_i[0].delta;
    if (lane_i[1].delta > dmax) begin
      dmax = lane_i[1].delta;
    end
    if (lane_i[2].delta > dmax) begin
      dmax = lane_i[2].delta;
    end
    if (dmax > 0) begin
      dmax = '0;
    end
    any_out = lane_i[0].bx_out | lane_i[1].bx_out | lane_i[2].bx_out;
    all_in  = lane_i[0].bx_in & lane_i[1].bx_in & lane_i[2].bx_in;
    priority if (any_out) begin
      rel = boxq_pkg::REL_OUTSIDE;
    end else if (all_in) begin
      rel = boxq_pkg::REL_INSIDE;
    end else begin
      rel = boxq_pkg::REL_CROSS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      merge_q.rem   <= sum;
      merge_q.root  <= '0;
      merge_q.dmax  <= dmax;
      merge_q.pt_in <= lane_i[0].pt_in & lane_i[1].pt_in & lane_i[2].pt_in;
      merge_q.rel   <= rel;
      merge_q.kind  <= kind_i;
    end
  end

  assign merge_o = merge_q;

endmodule

### design/boxq_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries the query sideband alongside. Depends on boxq_pkg.
`timescale 1ns / 1ps

module boxq_sqrt (
  input  logic                              clk_i,
  input  logic [boxq_pkg::ROOT_STEPS-1:0]   en_i,
  input  boxq_pkg::root_t                   root_i,
  output boxq_pkg::root_t                   root_o
);

  boxq_pkg::root_t stg_q [boxq_pkg::ROOT_STEPS];

  for (genvar j = 0; j < boxq_pkg::ROOT_STEPS; j++) begin : g_step
    localparam logic [boxq_pkg::SQ_W-1:0] BIT =
      64'd1 << (boxq_pkg::SQ_W - 2 - 2 * j);

    boxq_pkg::root_t           cur;
    boxq_pkg::root_t           nxt;
    logic [boxq_pkg::SQ_W-1:0] trial;

    always_comb begin
      cur   = (j == 0) ? root_i : stg_q[(j == 0) ? 0 : j - 1];
      nxt   = cur;
      trial = cur.root + BIT;
      if (cur.rem >= trial) begin
        nxt.rem  = cur.rem - trial;
        nxt.root = (cur.root >> 1) + BIT;
      end else begin
        nxt.root = cur.root >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        stg_q[j] <= nxt;
      end
    end
  end

  assign root_o = stg_q[boxq_pkg::ROOT_STEPS-1];

endmodule

### design/box_distance_and_overlap_query.sv
// Top level of the box distance and overlap query block.
// Instantiates boxq_lane, boxq_merge and boxq_sqrt; depends on boxq_pkg.
//
//   Channel   Direction  Content
//   s_axis    in         tdata: pos_x, pos_y, pos_z, top_x, top_y, top_z; tuser: kind
//   m_axis    out        tdata: distance, point_inside, relation, zero fill
//   cfg       in         write of size_x, size_y or size_z by register index
//
// One transaction is accepted per cycle unless the output stalls; each passes the two lane
// stages, the merge stage, the square root steps (one result bit each) and the output register.
// Reset clears all stage valid flags and sets every box size to 1.0.
// Empty stages absorb new transactions while a finished result waits on the output.
`timescale 1ns / 1ps

module box_distance_and_overlap_query (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // Fields from bit 0: pos_x, pos_y, pos_z, top_x, top_y, top_z.
  input  logic [boxq_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // Field: kind.
  input  logic                                 s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // Fields from bit 0: distance, point_inside, relation, zero fill; kind 0 sets the first two, kind 1 only relation.
  output logic [boxq_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  input  logic                                 cfg_we_i,
  input  logic [boxq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [boxq_pkg::COORD_W-1:0]         cfg_data_i
);

  localparam int unsigned LAST = boxq_pkg::NUM_STAGES - 1;

  logic [boxq_pkg::COORD_W-1:0]        size_q [boxq_pkg::NUM_AXES];
  logic [boxq_pkg::NUM_STAGES-1:0]     vld_q;
  logic [boxq_pkg::NUM_STAGES-1:0]     adv;
  logic [1:0]                          kind_q;
  boxq_pkg::lane_t [boxq_pkg::NUM_AXES-1:0] lanes;
  boxq_pkg::root_t                     merged;
  boxq_pkg::root_t                     rooted;
  logic signed [boxq_pkg::DIST_W-1:0]  distance;
  logic [boxq_pkg::OUT_DATA_W-1:0]     out_d;
  logic [boxq_pkg::OUT_DATA_W-1:0]     out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < boxq_pkg::NUM_AXES; a++) begin
        size_q[a] <= boxq_pkg::SIZE_RESET;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        boxq_pkg::REG_SIZE_X: size_q[0] <= cfg_data_i;
        boxq_pkg::REG_SIZE_Y: size_q[1] <= cfg_data_i;
        boxq_pkg::REG_SIZE_Z: size_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    adv[LAST] = !vld_q[LAST] || m_axis_tready_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < boxq_pkg::NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld_q[k] <= (k == 0) ? s_axis_tvalid_i : vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      kind_q[0] <= s_axis_tuser_i;
    end
    if (adv[1]) begin
      kind_q[1] <= kind_q[0];
    end
  end

  for (genvar a = 0; a < boxq_pkg::NUM_AXES; a++) begin : g_lane
    boxq_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv[1:0]),
      .pos_i  ($signed(s_axis_tdata_i[a*boxq_pkg::COORD_W +: boxq_pkg::COORD_W])),
      .top_i  ($signed(s_axis_tdata_i[(a+boxq_pkg::NUM_AXES)*boxq_pkg::COORD_W
                                      +: boxq_pkg::COORD_W])),
      .half_i (size_q[a][boxq_pkg::COORD_W-1:1]),
      .lane_o (lanes[a])
    );
  end

  boxq_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (adv[2]),
    .lane_i  (lanes),
    .kind_i  (kind_q[1]),
    .merge_o (merged)
  );

  boxq_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv[LAST-1:3]),
    .root_i (merged),
    .root_o (rooted)
  );

  always_comb begin
    distance = $signed({1'b0, rooted.root[boxq_pkg::COORD_W-1:0]}) + rooted.dmax;
    out_d    = '0;
    if (rooted.kind) begin
      out_d[boxq_pkg::DIST_W+2:boxq_pkg::DIST_W+1] = rooted.rel;
    end else begin
      out_d[boxq_pkg::DIST_W-1:0] = distance;
      out_d[boxq_pkg::DIST_W]     = rooted.pt_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[LAST]) begin
      out_q <= out_d;
    end
  end

  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = vld_q[LAST];
  assign m_axis_tdata_o  = out_q;

endmodule
